### rtl/pfspf_pkg.sv
// pfspf_pkg: shared constants for the per-flow stale packet filter
// field widths, register indexes and register reset values; no dependencies
package pfspf_pkg;

  localparam int TARGET_W = 13;
  localparam int SOURCE_W = 16;
  localparam int RTIME_W  = 16;
  localparam int LTIME_W  = 32;
  localparam int KEY_W    = TARGET_W + SOURCE_W;
  localparam int TIMES_W  = RTIME_W + LTIME_W;

  localparam int NEAR_W   = 16;
  localparam int AGE_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_SCALE   = 2'd1;

  localparam logic [NEAR_W-1:0] NEAR_WINDOW_RST = 16'd1000;
  localparam logic [AGE_W-1:0]  AGE_SCALE_RST   = 8'd110;

endpackage

### rtl/per_flow_stale_packet_filter.sv
// per_flow_stale_packet_filter: flow table lookup and stale packet decision
// depends on pfspf_pkg; holds the key memory and the time memory
//
// usage: one input word per packet (target, source, remote and arrival time),
// one output word per packet (toss, new_flow, table_full). both channels are
// valid/ready. cfg_we writes near_window (index 0) or age_scale (index 1);
// the user writes only while the block is idle (the block itself does not
// enforce it); other indexes are ignored. flows are kept in a key memory and
// a time memory, filled from slot 0 up; slots are never freed, so a fill
// count stands in for per-slot valid bits. one packet is handled at a time:
// the key memory is scanned one slot per cycle; a new flow then goes straight
// to the output stage, and a flow found in slot h passes through reading its
// times, comparing and writing back, and loading the output register. the
// next word is accepted as soon as the result sits in the output register,
// even if it is not yet taken.
// reset (synchronous, active low) empties the table at once and restores
// the register defaults; no clearing pass. a stalled receiver holds the
// finished result in the output stage and the block waits there before
// loading a newer one.
module per_flow_stale_packet_filter #(
  parameter int FLOW_SLOTS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pfspf_pkg::TARGET_W-1:0]      in_target_id,
  input  logic signed [pfspf_pkg::SOURCE_W-1:0] in_source_id,
  input  logic [pfspf_pkg::RTIME_W-1:0]       in_remote_time,
  input  logic [pfspf_pkg::LTIME_W-1:0]       in_arrival_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_toss,
  output logic                                out_new_flow,
  output logic                                out_table_full,
  input  logic                                cfg_we,
  input  logic [pfspf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfspf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int CW = $clog2(FLOW_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(FLOW_SLOTS);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_RDT, S_CMP, S_OUT} state_t;

  state_t state_r;

  logic [pfspf_pkg::NEAR_W-1:0]  near_r;
  logic [pfspf_pkg::AGE_W-1:0]   age_r;

  logic [pfspf_pkg::KEY_W-1:0]   key_mem  [FLOW_SLOTS];
  logic [pfspf_pkg::TIMES_W-1:0] time_mem [FLOW_SLOTS];

  logic [CW-1:0]                 fill_r;
  logic [CW-1:0]                 idx_r;
  logic                          pend_r;
  logic [AW-1:0]                 hit_r;
  logic [pfspf_pkg::KEY_W-1:0]   key_r;
  logic [pfspf_pkg::KEY_W-1:0]   key_rd_r;
  logic [pfspf_pkg::TIMES_W-1:0] time_rd_r;
  logic [pfspf_pkg::RTIME_W-1:0] rtime_r;
  logic [pfspf_pkg::LTIME_W-1:0] ltime_r;
  logic                          res_toss_r;
  logic                          res_new_r;
  logic                          res_full_r;
  logic                          out_valid_r;
  logic                          out_toss_r;
  logic                          out_new_r;
  logic                          out_full_r;

  logic                          issue;
  logic                          key_hit;
  logic [AW-1:0]                 hit_idx;
  logic                          tm_we;
  logic [AW-1:0]                 tm_waddr;
  logic                          km_we;
  logic [pfspf_pkg::RTIME_W-1:0] rdelta;
  logic [pfspf_pkg::LTIME_W-1:0] ldiff;
  logic [pfspf_pkg::RTIME_W+pfspf_pkg::AGE_W-1:0] scaled;
  logic                          keep;
  logic                          in_fire;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign issue    = (state_r == S_SCAN) && (idx_r < fill_r);
  assign key_hit  = pend_r && (key_rd_r == key_r);
  assign hit_idx  = AW'(idx_r - CW'(1));

  // hit update
  assign rdelta = rtime_r - time_rd_r[pfspf_pkg::TIMES_W-1:pfspf_pkg::LTIME_W];
  assign ldiff  = ltime_r - time_rd_r[pfspf_pkg::LTIME_W-1:0];
  assign scaled = rdelta * age_r;
  assign keep   = (rdelta < near_r) ||
                  ($signed({9'b0, scaled}) < $signed({ldiff[pfspf_pkg::LTIME_W-1], ldiff}));

  // memory write selection
  always_comb begin
    km_we    = 1'b0;
    tm_we    = 1'b0;
    tm_waddr = hit_r;
    if (state_r == S_SCAN && !key_hit && idx_r == fill_r && fill_r < SLOTS_C) begin
      km_we    = 1'b1;
      tm_we    = 1'b1;
      tm_waddr = fill_r[AW-1:0];
    end else if (state_r == S_CMP && keep) begin
      tm_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (km_we) begin
      key_mem[fill_r[AW-1:0]] <= key_r;
    end
    if (issue) begin
      key_rd_r <= key_mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (tm_we) begin
      time_mem[tm_waddr] <= {rtime_r, ltime_r};
    end
    if (state_r == S_RDT) begin
      time_rd_r <= time_mem[hit_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= pfspf_pkg::NEAR_WINDOW_RST;
      age_r  <= pfspf_pkg::AGE_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfspf_pkg::CFG_NEAR_WINDOW: near_r <= cfg_data[pfspf_pkg::NEAR_W-1:0];
        pfspf_pkg::CFG_AGE_SCALE:   age_r  <= cfg_data[pfspf_pkg::AGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            key_r   <= {in_target_id, in_source_id};
            rtime_r <= in_remote_time;
            ltime_r <= in_arrival_time;
            idx_r   <= '0;
            pend_r  <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend_r <= issue && !key_hit;
          if (issue) begin
            idx_r <= idx_r + CW'(1);
          end
          if (key_hit) begin
            hit_r   <= hit_idx;
            state_r <= S_RDT;
          end else if (idx_r == fill_r) begin
            res_toss_r <= 1'b0;
            res_new_r  <= 1'b1;
            res_full_r <= (fill_r == SLOTS_C);
            if (fill_r < SLOTS_C) begin
              fill_r <= fill_r + CW'(1);
            end
            state_r <= S_OUT;
          end
        end
        S_RDT: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          res_toss_r <= !keep;
          res_new_r  <= 1'b0;
          res_full_r <= 1'b0;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_toss_r  <= res_toss_r;
            out_new_r   <= res_new_r;
            out_full_r  <= res_full_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_toss       = out_toss_r;
  assign out_new_flow   = out_new_r;
  assign out_table_full = out_full_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= SLOTS_C && idx_r <= fill_r)
    else $error("fill count or scan index out of range");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && fill_r != $past(fill_r)) |-> fill_r == $past(fill_r) + CW'(1))
    else $error("fill count moved by more than one");

  a_word_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!out_full_r || out_new_r) && !(out_toss_r && out_new_r)))
    else $error("inconsistent output word flags");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_toss_r))
    else $error("output word overwritten while stalled");

endmodule
